// File: rtl/dpc_pkg.sv
package dpc_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int EPS_W      = 36;
   localparam int LBL_W      = IDX_W + 1;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_EPS_SQUARED = 1'b0,
      CSR_MIN_POINTS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type                 action;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic signed [COORD_W-1:0]  z_coord;
      logic [IDX_W-1:0]           point_index;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_SEED_ADDR,
      ST_SEED_CHK,
      ST_SC_ADDR,
      ST_SC_MUL,
      ST_SC_CMP,
      ST_SCAN_END,
      ST_POP,
      ST_POP_WAIT,
      ST_POP_CHK
   } state_type;

endpackage

// File: rtl/dpc_front.sv
module dpc_front import dpc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 req_action,
   input  logic signed [COORD_W-1:0]  req_x_coord,
   input  logic signed [COORD_W-1:0]  req_y_coord,
   input  logic signed [COORD_W-1:0]  req_z_coord,
   input  logic [IDX_W-1:0]           req_point_index,
   input  logic                       take,
   output logic                       busy,
   output logic                       cmd_valid,
   output cmd_type                    cmd
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       pop;
   cmd_type    new_cmd;

   assign busy      = (count_ff == 2'd2);
   assign accept    = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = take && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.action      = action_type'(req_action);
      new_cmd.x_coord     = req_x_coord;
      new_cmd.y_coord     = req_y_coord;
      new_cmd.z_coord     = req_z_coord;
      new_cmd.point_index = req_point_index;
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/dpc_back.sv
module dpc_back import dpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   input  logic [EPS_W-1:0]  eps_squared,
   input  logic [CNT_W-1:0]  min_points,
   output logic              take,
   output logic              rsp_strobe,
   output logic              rsp_in_cluster,
   output logic [IDX_W-1:0]  rsp_cluster_id,
   output logic [CNT_W-1:0]  rsp_cluster_total,
   output logic [CNT_W-1:0]  rsp_points_loaded,
   output logic              rsp_error_flag
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);

   logic [3*COORD_W-1:0] pt_mem  [MAX_POINTS];
   logic [LBL_W-1:0]     lbl_mem [MAX_POINTS];
   logic [CNT_W-1:0]     qt_mem  [MAX_POINTS];
   logic [IDX_W-1:0]     stk_mem [MAX_POINTS];

   logic [3*COORD_W-1:0] pt_rd_ff;
   logic [LBL_W-1:0]     lbl_rd_ff;
   logic [CNT_W-1:0]     qt_rd_ff;
   logic [IDX_W-1:0]     stk_rd_ff;

   logic [IDX_W-1:0]     pt_ra, lbl_ra, qt_ra, stk_ra;
   logic                 pt_we, lbl_we, qt_we, stk_we;
   logic [IDX_W-1:0]     pt_wa, lbl_wa, qt_wa, stk_wa;
   logic [3*COORD_W-1:0] pt_wd;
   logic [LBL_W-1:0]     lbl_wd;
   logic [CNT_W-1:0]     qt_wd;
   logic [IDX_W-1:0]     stk_wd;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     cluster_ff, cluster_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     q_ff, q_in;
   logic [3*COORD_W-1:0] p_ff, p_in;
   logic                 is_pop_ff, is_pop_in;
   logic                 push_ff, push_in;
   logic [SQ_W-1:0]      sq_ff [3];
   logic [SQ_W-1:0]      sq_in [3];
   logic                 vis_ff, vis_in;
   logic                 qd_ff, qd_in;

   logic                 strobe_in;
   logic                 inc_in, err_in;
   logic [IDX_W-1:0]     cid_in;
   logic [CNT_W-1:0]     tag;
   logic [EPS_W-1:0]     sq_sum;
   logic                 near;
   logic signed [DIFF_W-1:0] diff [3];

   assign tag    = cluster_ff + CNT_W'(1);
   assign sq_sum = EPS_W'(sq_ff[0]) + EPS_W'(sq_ff[1]) + EPS_W'(sq_ff[2]);
   assign near   = (sq_sum < eps_squared);

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         diff[d] = $signed({p_ff[d*COORD_W + COORD_W-1], p_ff[d*COORD_W +: COORD_W]})
                 - $signed({pt_rd_ff[d*COORD_W + COORD_W-1], pt_rd_ff[d*COORD_W +: COORD_W]});
         sq_in[d] = diff[d] * diff[d];
      end
   end

   always_ff @(posedge clock) begin
      pt_rd_ff  <= pt_mem[pt_ra];
      lbl_rd_ff <= lbl_mem[lbl_ra];
      qt_rd_ff  <= qt_mem[qt_ra];
      stk_rd_ff <= stk_mem[stk_ra];
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      if (lbl_we) begin
         lbl_mem[lbl_wa] <= lbl_wd;
      end
      if (qt_we) begin
         qt_mem[qt_wa] <= qt_wd;
      end
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cnt_in     = cnt_ff;
      depth_in   = depth_ff;
      cluster_in = cluster_ff;
      loaded_in  = loaded_ff;
      idx_in     = idx_ff;
      q_in       = q_ff;
      p_in       = p_ff;
      is_pop_in  = is_pop_ff;
      push_in    = push_ff;
      vis_in     = vis_ff;
      qd_in      = qd_ff;
      take       = 1'b0;
      strobe_in  = 1'b0;
      inc_in     = 1'b0;
      err_in     = 1'b0;
      cid_in     = '0;
      pt_ra      = j_ff[IDX_W-1:0];
      lbl_ra     = j_ff[IDX_W-1:0];
      qt_ra      = j_ff[IDX_W-1:0];
      stk_ra     = '0;
      pt_we      = 1'b0;
      lbl_we     = 1'b0;
      qt_we      = 1'b0;
      stk_we     = 1'b0;
      pt_wa      = loaded_ff[IDX_W-1:0];
      lbl_wa     = j_ff[IDX_W-1:0];
      qt_wa      = j_ff[IDX_W-1:0];
      stk_wa     = depth_ff[IDX_W-1:0];
      pt_wd      = {cmd.x_coord, cmd.y_coord, cmd.z_coord};
      lbl_wd     = '0;
      qt_wd      = '0;
      stk_wd     = j_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            lbl_ra = cmd.point_index;
            if (cmd_valid) begin
               take = 1'b1;
               case (cmd.action)
                  ACT_CLEAR: begin
                     loaded_in  = '0;
                     cluster_in = '0;
                     strobe_in  = 1'b1;
                  end
                  ACT_LOAD: begin
                     strobe_in = 1'b1;
                     if (loaded_ff == FULL) begin
                        err_in = 1'b1;
                     end else begin
                        pt_we     = 1'b1;
                        lbl_we    = 1'b1;
                        lbl_wa    = loaded_ff[IDX_W-1:0];
                        loaded_in = loaded_ff + CNT_W'(1);
                     end
                  end
                  ACT_RUN: begin
                     j_in       = '0;
                     cluster_in = '0;
                     state_in   = ST_SWEEP;
                  end
                  ACT_READ: begin
                     idx_in   = cmd.point_index;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            strobe_in = 1'b1;
            if ({1'b0, idx_ff} >= loaded_ff) begin
               err_in = 1'b1;
            end else if (lbl_rd_ff[LBL_W-1]) begin
               inc_in = 1'b1;
               cid_in = lbl_rd_ff[IDX_W-1:0];
            end
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (j_ff == loaded_ff) begin
               i_in     = '0;
               state_in = ST_SEED_ADDR;
            end else begin
               lbl_we = 1'b1;
               qt_we  = 1'b1;
               j_in   = j_ff + CNT_W'(1);
            end
         end
         ST_SEED_ADDR: begin
            pt_ra  = i_ff[IDX_W-1:0];
            lbl_ra = i_ff[IDX_W-1:0];
            if (i_ff == loaded_ff) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_SEED_CHK;
            end
         end
         ST_SEED_CHK: begin
            if (lbl_rd_ff[LBL_W-1]) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SEED_ADDR;
            end else begin
               p_in      = pt_rd_ff;
               is_pop_in = 1'b0;
               push_in   = 1'b0;
               j_in      = '0;
               cnt_in    = '0;
               state_in  = ST_SC_ADDR;
            end
         end
         ST_SC_ADDR: begin
            state_in = (j_ff == loaded_ff) ? ST_SCAN_END : ST_SC_MUL;
         end
         ST_SC_MUL: begin
            vis_in   = lbl_rd_ff[LBL_W-1];
            qd_in    = (qt_rd_ff == tag);
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (push_ff) begin
               if (near && !vis_ff && !qd_ff && (depth_ff < FULL)) begin
                  qt_we    = 1'b1;
                  qt_wd    = tag;
                  stk_we   = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
            end else if (near) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            j_in     = j_ff + CNT_W'(1);
            state_in = ST_SC_ADDR;
         end
         ST_SCAN_END: begin
            if (push_ff) begin
               state_in = ST_POP;
            end else if (cnt_ff >= min_points) begin
               push_in  = 1'b1;
               j_in     = '0;
               state_in = ST_SC_ADDR;
               if (!is_pop_ff) begin
                  lbl_we   = 1'b1;
                  lbl_wa   = i_ff[IDX_W-1:0];
                  lbl_wd   = {1'b1, cluster_ff[IDX_W-1:0]};
                  depth_in = '0;
               end
            end else if (is_pop_ff) begin
               state_in = ST_POP;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SEED_ADDR;
            end
         end
         ST_POP: begin
            stk_ra = depth_ff[IDX_W-1:0] - IDX_W'(1);
            if (depth_ff == '0) begin
               cluster_in = cluster_ff + CNT_W'(1);
               i_in       = i_ff + CNT_W'(1);
               state_in   = ST_SEED_ADDR;
            end else begin
               depth_in = depth_ff - CNT_W'(1);
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            pt_ra    = stk_rd_ff;
            lbl_ra   = stk_rd_ff;
            q_in     = stk_rd_ff;
            state_in = ST_POP_CHK;
         end
         ST_POP_CHK: begin
            if (lbl_rd_ff[LBL_W-1]) begin
               state_in = ST_POP;
            end else begin
               lbl_we    = 1'b1;
               lbl_wa    = q_ff;
               lbl_wd    = {1'b1, cluster_ff[IDX_W-1:0]};
               p_in      = pt_rd_ff;
               is_pop_in = 1'b1;
               push_in   = 1'b0;
               j_in      = '0;
               cnt_in    = '0;
               state_in  = ST_SC_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      q_ff      <= q_in;
      p_ff      <= p_in;
      is_pop_ff <= is_pop_in;
      push_ff   <= push_in;
      vis_ff    <= vis_in;
      qd_ff     <= qd_in;
      depth_ff  <= depth_in;
      for (int d = 0; d < 3; d++) begin
         sq_ff[d] <= sq_in[d];
      end
      if (strobe_in) begin
         rsp_in_cluster    <= inc_in;
         rsp_cluster_id    <= cid_in;
         rsp_cluster_total <= cluster_in;
         rsp_points_loaded <= loaded_in;
         rsp_error_flag    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cluster_ff <= '0;
         loaded_ff  <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cluster_ff <= cluster_in;
         loaded_ff  <= loaded_in;
         rsp_strobe <= strobe_in;
      end
   end

endmodule

// File: rtl/density_point_clustering.sv
// Density clustering of up to 1024 three-dimensional points. A transaction is taken when
// start is high and busy is low; a two-entry queue holds transactions while the executing
// part works, and busy rises only when that queue is full. Every transaction yields one
// result, shown for a single cycle with rsp_strobe high; the receiver cannot stall it, so
// it must take each result as it appears. A clear or a load shows its result in the cycle
// after it leaves the queue, and a label read only after passing the read state as well;
// a taken transaction is registered in the queue and leaves it when the executing part is
// idle. A run first clears the labels and stack marks of the n loaded points, then for
// every unlabelled point taken from a seed or from the work stack scans all n points
// through the single read port of the point memory, in address, multiply and compare steps
// for each point, once to count neighbours and once more to push them when the point is core.
module density_point_clustering import dpc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_action,
   input  logic signed [COORD_W-1:0]  req_x_coord,
   input  logic signed [COORD_W-1:0]  req_y_coord,
   input  logic signed [COORD_W-1:0]  req_z_coord,
   input  logic [IDX_W-1:0]           req_point_index,
   output logic                       rsp_strobe,
   output logic                       rsp_in_cluster,
   output logic [IDX_W-1:0]           rsp_cluster_id,
   output logic [CNT_W-1:0]           rsp_cluster_total,
   output logic [CNT_W-1:0]           rsp_points_loaded,
   output logic                       rsp_error_flag,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [EPS_W-1:0]           csr_data
);

   logic [EPS_W-1:0] eps_ff;
   logic [CNT_W-1:0] minp_ff;
   logic             cmd_valid;
   logic             take;
   cmd_type          cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff  <= '0;
         minp_ff <= CNT_W'(4);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_EPS_SQUARED: eps_ff  <= csr_data;
            CSR_MIN_POINTS:  minp_ff <= csr_data[CNT_W-1:0];
            default:         eps_ff  <= eps_ff;
         endcase
      end
   end

   dpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_action      (req_action),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .req_point_index (req_point_index),
      .take            (take),
      .busy            (busy),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd)
   );

   dpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .eps_squared       (eps_ff),
      .min_points        (minp_ff),
      .take              (take),
      .rsp_strobe        (rsp_strobe),
      .rsp_in_cluster    (rsp_in_cluster),
      .rsp_cluster_id    (rsp_cluster_id),
      .rsp_cluster_total (rsp_cluster_total),
      .rsp_points_loaded (rsp_points_loaded),
      .rsp_error_flag    (rsp_error_flag)
   );

endmodule

// File: sim/tb_density_point_clustering.sv
module tb_density_point_clustering import dpc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 600000;

   typedef struct {
      bit             in_cluster;
      bit [IDX_W-1:0] cluster_id;
      bit [CNT_W-1:0] cluster_total;
      bit [CNT_W-1:0] points_loaded;
      bit             error_flag;
   } label_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_action = '0;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic signed [COORD_W-1:0] req_z_coord = '0;
   logic [IDX_W-1:0]          req_point_index = '0;
   logic                      rsp_strobe;
   logic                      rsp_in_cluster;
   logic [IDX_W-1:0]          rsp_cluster_id;
   logic [CNT_W-1:0]          rsp_cluster_total;
   logic [CNT_W-1:0]          rsp_points_loaded;
   logic                      rsp_error_flag;
   logic                      csr_write = 1'b0;
   logic                      csr_index = 1'b0;
   logic [EPS_W-1:0]          csr_data = '0;

   density_point_clustering i_dut (.*);

   always #6 clock = ~clock;

   cmd_type         pending_cmds[$];
   label_reply_type expected_replies[$];
   cmd_type         held_cmd;
   int              idle_pct = 0;
   int              fail_count = 0;
   int              quiet_cycles = 0;

   // Shadow copy of the clustering state.
   logic signed [COORD_W-1:0] pt_x[MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y[MAX_POINTS];
   logic signed [COORD_W-1:0] pt_z[MAX_POINTS];
   bit                        seen[MAX_POINTS];
   bit                        stacked[MAX_POINTS];
   bit                        labelled[MAX_POINTS];
   int                        label_of[MAX_POINTS];
   int                        grow_stack[MAX_POINTS];
   int                        grow_depth;
   int                        n_loaded = 0;
   int                        n_clusters = 0;
   longint                    radius_sq = 0;
   int                        core_min = 4;

   function automatic void enqueue(cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   function automatic bit is_near(int a, int b);
      longint dx, dy, dz;
      dx = longint'(pt_x[a]) - longint'(pt_x[b]);
      dy = longint'(pt_y[a]) - longint'(pt_y[b]);
      dz = longint'(pt_z[a]) - longint'(pt_z[b]);
      return (dx * dx + dy * dy + dz * dz) < radius_sq;
   endfunction

   function automatic int count_near(int p);
      int c;
      c = 0;
      for (int j = 0; j < n_loaded; j++) if (is_near(p, j)) c++;
      return c;
   endfunction

   task automatic stack_neighbours(int p);
      for (int j = 0; j < n_loaded; j++) begin
         if (is_near(p, j) && !seen[j] && !stacked[j] && grow_depth < MAX_POINTS) begin
            stacked[j] = 1'b1;
            grow_stack[grow_depth++] = j;
         end
      end
   endtask

   task automatic find_clusters();
      int q;
      for (int k = 0; k < MAX_POINTS; k++) begin
         seen[k] = 1'b0;
         labelled[k] = 1'b0;
         label_of[k] = 0;
      end
      n_clusters = 0;
      for (int i = 0; i < n_loaded; i++) begin
         if (!seen[i] && count_near(i) >= core_min) begin
            seen[i] = 1'b1;
            labelled[i] = 1'b1;
            label_of[i] = n_clusters;
            for (int k = 0; k < MAX_POINTS; k++) stacked[k] = 1'b0;
            grow_depth = 0;
            stack_neighbours(i);
            while (grow_depth > 0) begin
               q = grow_stack[--grow_depth];
               if (!seen[q]) begin
                  seen[q] = 1'b1;
                  labelled[q] = 1'b1;
                  label_of[q] = n_clusters;
                  if (count_near(q) >= core_min) stack_neighbours(q);
               end
            end
            n_clusters++;
         end
      end
   endtask

   task automatic predict_reply(cmd_type c);
      label_reply_type r;
      int idx;
      r = '{default: 0};
      case (c.action)
         ACT_CLEAR: begin
            n_loaded = 0;
            n_clusters = 0;
            for (int k = 0; k < MAX_POINTS; k++) begin
               labelled[k] = 1'b0;
               label_of[k] = 0;
            end
         end
         ACT_LOAD: begin
            if (n_loaded >= MAX_POINTS) begin
               r.error_flag = 1'b1;
            end else begin
               pt_x[n_loaded] = c.x_coord;
               pt_y[n_loaded] = c.y_coord;
               pt_z[n_loaded] = c.z_coord;
               labelled[n_loaded] = 1'b0;
               label_of[n_loaded] = 0;
               n_loaded++;
            end
         end
         ACT_RUN: find_clusters();
         default: begin
            idx = int'(c.point_index);
            if (idx >= n_loaded) begin
               r.error_flag = 1'b1;
            end else if (labelled[idx]) begin
               r.in_cluster = 1'b1;
               r.cluster_id = label_of[idx][IDX_W-1:0];
            end
         end
      endcase
      r.cluster_total = n_clusters[CNT_W-1:0];
      r.points_loaded = n_loaded[CNT_W-1:0];
      expected_replies.insert(expected_replies.size(), r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_reply(held_cmd);
         if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
               held_cmd = pending_cmds.pop_front();
               start <= 1'b1;
               req_action <= held_cmd.action;
               req_x_coord <= held_cmd.x_coord;
               req_y_coord <= held_cmd.y_coord;
               req_z_coord <= held_cmd.z_coord;
               req_point_index <= held_cmd.point_index;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      label_reply_type e;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected transaction on the result channel");
            fail_count++;
         end else begin
            e = expected_replies.pop_front();
            if (rsp_in_cluster !== e.in_cluster) begin
               $error("in_cluster: expected %0d, got %0d", e.in_cluster, rsp_in_cluster);
               fail_count++;
            end
            if (rsp_cluster_id !== e.cluster_id) begin
               $error("cluster_id: expected %0d, got %0d", e.cluster_id, rsp_cluster_id);
               fail_count++;
            end
            if (rsp_cluster_total !== e.cluster_total) begin
               $error("cluster_total: expected %0d, got %0d", e.cluster_total,
                      rsp_cluster_total);
               fail_count++;
            end
            if (rsp_points_loaded !== e.points_loaded) begin
               $error("points_loaded: expected %0d, got %0d", e.points_loaded,
                      rsp_points_loaded);
               fail_count++;
            end
            if (rsp_error_flag !== e.error_flag) begin
               $error("error_flag: expected %0d, got %0d", e.error_flag, rsp_error_flag);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic cmd_type make_cmd(action_type a, int x, int y, int z, int idx);
      cmd_type c;
      c.action = a;
      c.x_coord = x[COORD_W-1:0];
      c.y_coord = y[COORD_W-1:0];
      c.z_coord = z[COORD_W-1:0];
      c.point_index = idx[IDX_W-1:0];
      return c;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int near_coord(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic drain();
      wait (pending_cmds.size() == 0 && expected_replies.size() == 0 && !start);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [EPS_W-1:0] value);
      drain();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_EPS_SQUARED) radius_sq = longint'(value);
      else core_min = int'(value[CNT_W-1:0]);
   endtask

   // A clustered point set: a few centres, points scattered around them,
   // some outliers, then a run and reads over and past the loaded range.
   task automatic queue_point_set(int n, int spread);
      int cx[4], cy[4], cz[4];
      int c;
      enqueue(make_cmd(ACT_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(1023)));
      for (int k = 0; k < 4; k++) begin
         cx[k] = rand_coord();
         cy[k] = rand_coord();
         cz[k] = rand_coord();
      end
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(3);
         if ($urandom_range(9) == 0)
            enqueue(make_cmd(ACT_LOAD, rand_coord(), rand_coord(), rand_coord(),
                             $urandom_range(1023)));
         else
            enqueue(make_cmd(ACT_LOAD, near_coord(cx[c], spread), near_coord(cy[c], spread),
                             near_coord(cz[c], spread), $urandom_range(1023)));
      end
      enqueue(make_cmd(ACT_RUN, rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(1023)));
      for (int i = 0; i < n + 2; i++)
         enqueue(make_cmd(ACT_READ, rand_coord(), rand_coord(), rand_coord(),
                          ($urandom_range(3) == 0) ? $urandom_range(1023) : i));
      if ($urandom_range(1) == 1) begin
         enqueue(make_cmd(ACT_LOAD, cx[0], cy[0], cz[0], 0));
         enqueue(make_cmd(ACT_READ, 0, 0, 0, n));
         enqueue(make_cmd(ACT_READ, 0, 0, 0, 0));
      end
      if ($urandom_range(3) == 0)
         enqueue(make_cmd(action_type'($urandom_range(3)), rand_coord(), rand_coord(),
                          rand_coord(), $urandom_range(1023)));
   endtask

   initial begin
      logic [EPS_W-1:0] eps_value;
      int idle_modes[4];
      idle_modes = '{0, 49, 49, 37};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset settings, then with a wide radius.
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_RUN, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_LOAD, -32768, -32768, -32768, 0));
      enqueue(make_cmd(ACT_LOAD, 32767, 32767, 32767, 1023));
      enqueue(make_cmd(ACT_LOAD, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_LOAD, 1, -1, 0, 0));
      enqueue(make_cmd(ACT_RUN, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 3));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 4));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 1023));
      write_csr(CSR_EPS_SQUARED, '1);
      write_csr(CSR_MIN_POINTS, 11'd1);
      enqueue(make_cmd(ACT_RUN, 0, 0, 0, 0));
      for (int i = 0; i < 5; i++) enqueue(make_cmd(ACT_READ, 0, 0, 0, i));
      enqueue(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 0));
      write_csr(CSR_EPS_SQUARED, 36'd3);
      write_csr(CSR_MIN_POINTS, 11'd1024);
      queue_point_set(6, 1);
      write_csr(CSR_MIN_POINTS, 11'd2);
      queue_point_set(6, 1);

      // Random point sets over several radii, core thresholds and idle rates.
      for (int s = 0; s < 6; s++) begin
         idle_pct = idle_modes[s % 4];
         if (s % 2 == 0) begin
            case ($urandom_range(5))
               0: eps_value = '0;
               1: eps_value = '1;
               2: eps_value = EPS_W'({$urandom, $urandom});
               default: eps_value = EPS_W'($urandom_range(2000));
            endcase
            write_csr(CSR_EPS_SQUARED, eps_value);
            write_csr(CSR_MIN_POINTS, ($urandom_range(7) == 0) ? EPS_W'(1024)
                                                                : EPS_W'($urandom_range(1, 5)));
         end
         queue_point_set($urandom_range(1, 16), $urandom_range(1, 20));
      end
      idle_pct = 37;
      write_csr(CSR_EPS_SQUARED, 36'd400);
      write_csr(CSR_MIN_POINTS, 11'd3);
      queue_point_set(24, 8);

      // Fill the store to capacity and beyond, with reads across the whole index range.
      idle_pct = 0;
      enqueue(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
      for (int i = 0; i < MAX_POINTS + 3; i++)
         enqueue(make_cmd(ACT_LOAD, rand_coord(), rand_coord(), rand_coord(), 0));
      for (int i = 0; i < 10; i++)
         enqueue(make_cmd(ACT_READ, 0, 0, 0, $urandom_range(1023)));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 1023));
      enqueue(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
      enqueue(make_cmd(ACT_READ, 0, 0, 0, 1023));

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
